// ===== design/xpak_container_parser_defines.svh =====
// ----------------------------------------------------------------------------
// xpak container parser assertion macros
// shared concurrent assertion forms, all disabled while reset is active
// ----------------------------------------------------------------------------
`ifndef XPAK_CONTAINER_PARSER_DEFINES_SVH
`define XPAK_CONTAINER_PARSER_DEFINES_SVH

// invariant that holds at every clock edge out of reset
`define XPAK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define XPAK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define XPAK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/xpak_pkg.sv =====
// ----------------------------------------------------------------------------
// xpak container parser package
// result kinds, status codes, magic strings and the result record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xpak_pkg;

  typedef enum logic [1:0] {
    KIND_NAME   = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_INTRO  = 3'd1,
    ST_TOTAL_LEN  = 3'd2,
    ST_IDX_OVERRUN = 3'd3,
    ST_SUM_MISMATCH = 3'd4,
    ST_BAD_OUTRO  = 3'd5,
    ST_EARLY_END  = 3'd6
  } status_e;

  localparam logic [63:0] INTRO_MAGIC = "XPAKPACK";
  localparam logic [63:0] OUTRO_MAGIC = "XPAKSTOP";

  // sum of entry lengths saturates here
  localparam logic [32:0] SUM_CAP = 33'h1_0000_0000;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [31:0] entry_offset;
    logic [31:0] entry_length;
    status_e     status;
  } result_t;

  // byte idx of an 8-char magic, first character first
  function automatic logic [7:0] magic_byte(input logic [63:0] magic, input logic [2:0] idx);
    return magic[{~idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== design/xpak_container_parser_if.sv =====
// ----------------------------------------------------------------------------
// xpak container parser stream interfaces
// byte input channel and result output channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xpak_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_final;

  modport source (output valid, output in_byte, output in_final, input ready);
  modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

interface xpak_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] entry_offset;
  logic [31:0] entry_length;
  logic [2:0]  status;

  modport source (output valid, output kind, output out_byte, output entry_offset,
                  output entry_length, output status, input ready);
  modport sink (input valid, input kind, input out_byte, input entry_offset,
                input entry_length, input status, output ready);
endinterface

// ===== design/xpak_parse_core.sv =====
// ----------------------------------------------------------------------------
// xpak parse core
// container state machine, one byte per step, result formed combinationally
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xpak_container_parser_defines.svh"

module xpak_parse_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             final_i,
  output xpak_pkg::result_t res_o
);
  import xpak_pkg::*;

  typedef enum logic [3:0] {
    PH_INTRO   = 4'd0,
    PH_IDXLEN  = 4'd1,
    PH_DATLEN  = 4'd2,
    PH_NAMELEN = 4'd3,
    PH_NAME    = 4'd4,
    PH_OFFSET  = 4'd5,
    PH_ELEN    = 4'd6,
    PH_DATA    = 4'd7,
    PH_OUTRO   = 4'd8,
    PH_DRAIN   = 4'd9
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  fbc_q, fbc_d;
  logic [31:0] word_q, word_d;
  logic [31:0] idx_left_q, idx_left_d;
  logic [31:0] total_q, total_d;
  logic [31:0] data_left_q, data_left_d;
  logic [31:0] name_left_q, name_left_d;
  logic [31:0] offset_q, offset_d;
  logic [32:0] sum_q, sum_d;
  status_e     err_q, err_d;

  logic [31:0] word_next;
  logic        word_done;
  logic [2:0]  fbc_word;
  logic [32:0] sum_add;
  logic        leave_idx;
  logic        outro_done;
  status_e     fail_code;
  result_t     res;

  assign word_next = {word_q[23:0], byte_i};
  assign word_done = (fbc_q >= 3'd3);
  assign fbc_word  = word_done ? 3'd0 : fbc_q + 3'd1;
  assign sum_add   = sum_q + {1'b0, word_next};

  always_comb begin
    phase_d     = phase_q;
    fbc_d       = fbc_q;
    word_d      = word_q;
    idx_left_d  = idx_left_q;
    total_d     = total_q;
    data_left_d = data_left_q;
    name_left_d = name_left_q;
    offset_d    = offset_q;
    sum_d       = sum_q;
    err_d       = err_q;
    leave_idx   = 1'b0;
    outro_done  = 1'b0;
    fail_code   = ST_OK;
    res         = '0;

    case (phase_q)
      PH_INTRO: begin
        if (byte_i != magic_byte(INTRO_MAGIC, fbc_q)) begin
          fail_code = ST_BAD_INTRO;
        end else if (fbc_q == 3'd7) begin
          fbc_d   = 3'd0;
          word_d  = '0;
          phase_d = PH_IDXLEN;
        end else begin
          fbc_d = fbc_q + 3'd1;
        end
      end
      PH_IDXLEN: begin
        word_d = word_next;
        fbc_d  = fbc_word;
        if (word_done) begin
          idx_left_d = word_next;
          phase_d    = PH_DATLEN;
        end
      end
      PH_DATLEN: begin
        word_d = word_next;
        fbc_d  = fbc_word;
        if (word_done) begin
          total_d = word_next;
          sum_d   = '0;
          if (idx_left_q == '0) begin
            leave_idx = 1'b1;
          end else begin
            phase_d = PH_NAMELEN;
          end
        end
      end
      PH_NAMELEN, PH_NAME, PH_OFFSET, PH_ELEN: begin
        idx_left_d = idx_left_q - 32'd1;
        case (phase_q)
          PH_NAMELEN: begin
            word_d = word_next;
            fbc_d  = fbc_word;
            if (word_done) begin
              name_left_d = word_next;
              phase_d     = (word_next == '0) ? PH_OFFSET : PH_NAME;
            end
          end
          PH_NAME: begin
            res.valid    = 1'b1;
            res.kind     = KIND_NAME;
            res.out_byte = byte_i;
            name_left_d  = name_left_q - 32'd1;
            if (name_left_q == 32'd1) begin
              fbc_d   = 3'd0;
              phase_d = PH_OFFSET;
            end
          end
          PH_OFFSET: begin
            word_d = word_next;
            fbc_d  = fbc_word;
            if (word_done) begin
              offset_d = word_next;
              phase_d  = PH_ELEN;
            end
          end
          default: begin
            word_d = word_next;
            fbc_d  = fbc_word;
            if (word_done) begin
              res.valid        = 1'b1;
              res.kind         = KIND_ENTRY;
              res.entry_offset = offset_q;
              res.entry_length = word_next;
              sum_d            = (sum_add > SUM_CAP) ? SUM_CAP : sum_add;
              phase_d          = PH_NAMELEN;
            end
          end
        endcase
        // index exhausted: fine only on an entry boundary
        if (idx_left_d == '0) begin
          if (phase_d == PH_NAMELEN && fbc_d == 3'd0) begin
            leave_idx = 1'b1;
          end else begin
            fail_code = ST_IDX_OVERRUN;
          end
        end
      end
      PH_DATA: begin
        res.valid    = 1'b1;
        res.kind     = KIND_DATA;
        res.out_byte = byte_i;
        data_left_d  = data_left_q - 32'd1;
        if (data_left_q == 32'd1) begin
          fbc_d   = 3'd0;
          phase_d = PH_OUTRO;
        end
      end
      PH_OUTRO: begin
        if (byte_i != magic_byte(OUTRO_MAGIC, fbc_q)) begin
          fail_code = ST_BAD_OUTRO;
        end else if (fbc_q == 3'd7) begin
          if (final_i) begin
            outro_done = 1'b1;
          end else begin
            fail_code = ST_TOTAL_LEN;
          end
        end else begin
          fbc_d = fbc_q + 3'd1;
        end
      end
      default: begin
        phase_d = PH_DRAIN;
      end
    endcase

    // end of index: check the length sum, then data or straight to outro
    if (leave_idx) begin
      fbc_d = 3'd0;
      if (sum_d != {1'b0, total_d}) begin
        fail_code = ST_SUM_MISMATCH;
      end else if (total_d == '0) begin
        phase_d = PH_OUTRO;
      end else begin
        data_left_d = total_d;
        phase_d     = PH_DATA;
      end
    end

    // first error sticks, rest of the container is swallowed
    if (fail_code != ST_OK) begin
      if (err_q == ST_OK) begin
        err_d = fail_code;
      end
      phase_d = PH_DRAIN;
      fbc_d   = 3'd0;
    end

    if (final_i) begin
      res        = '0;
      res.valid  = 1'b1;
      res.kind   = KIND_STATUS;
      res.status = (err_d != ST_OK) ? err_d : (outro_done ? ST_OK : ST_EARLY_END);
      phase_d     = PH_INTRO;
      fbc_d       = '0;
      word_d      = '0;
      idx_left_d  = '0;
      total_d     = '0;
      data_left_d = '0;
      name_left_d = '0;
      offset_d    = '0;
      sum_d       = '0;
      err_d       = ST_OK;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INTRO;
      fbc_q       <= '0;
      word_q      <= '0;
      idx_left_q  <= '0;
      total_q     <= '0;
      data_left_q <= '0;
      name_left_q <= '0;
      offset_q    <= '0;
      sum_q       <= '0;
      err_q       <= ST_OK;
    end else if (step_i) begin
      phase_q     <= phase_d;
      fbc_q       <= fbc_d;
      word_q      <= word_d;
      idx_left_q  <= idx_left_d;
      total_q     <= total_d;
      data_left_q <= data_left_d;
      name_left_q <= name_left_d;
      offset_q    <= offset_d;
      sum_q       <= sum_d;
      err_q       <= err_d;
    end
  end

  `XPAK_ASSERT_NEXT(a_final_restarts, clk_i, rst_ni, step_i && final_i, phase_q == PH_INTRO && err_q == ST_OK && fbc_q == 3'd0, "state not cleared after final byte")
  `XPAK_ASSERT_NEXT(a_drain_holds, clk_i, rst_ni, step_i && !final_i && phase_q == PH_DRAIN, phase_q == PH_DRAIN, "left drain before final byte")
  `XPAK_ASSERT_IMPL(a_err_in_drain, clk_i, rst_ni, err_q != ST_OK, phase_q == PH_DRAIN, "error recorded outside drain")
  `XPAK_ASSERT_IMPL(a_sum_saturated, clk_i, rst_ni, sum_q[32], sum_q[31:0] == '0, "length sum above cap")

endmodule

// ===== design/xpak_out_reg.sv =====
// ----------------------------------------------------------------------------
// xpak output register
// holds one result record and drives the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xpak_container_parser_defines.svh"

module xpak_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  xpak_pkg::result_t res_i,
  output logic              room_o,
  xpak_out_if.source        out_o
);
  import xpak_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign room_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.out_byte     = res_q.out_byte;
  assign out_o.entry_offset = res_q.entry_offset;
  assign out_o.entry_length = res_q.entry_length;
  assign out_o.status       = res_q.status;

  `XPAK_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, load_i, !valid_q || out_o.ready, "result overwritten before transfer")
  `XPAK_ASSERT_IMPL(a_status_only_final, clk_i, rst_ni, valid_q && res_q.kind != KIND_STATUS, res_q.status == ST_OK, "status set on a non-status result")

endmodule

// ===== design/xpak_container_parser.sv =====
// ----------------------------------------------------------------------------
// xpak container parser
// streaming parser for an xpak container: intro, index, data, outro checks
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                          transfer
//   in_i     in   in_byte[7:0], in_final                            valid & ready
//   out_o    out  kind[1:0], out_byte[7:0], entry_offset[31:0],     valid & ready
//                 entry_length[31:0], status[2:0]
//
// one byte per cycle sustained while the output channel is ready; a byte is held in the input
//   register and its result, if any, is loaded into the output register as the byte moves on
// the parse state machine updates once per byte, set by the input register
//   handing over to the output register
// reset (rst_ni low, async) empties both registers and returns to the intro phase
// a stalled output holds its result while one more byte waits in the input register
// bytes that produce no result pass without touching the output register
`timescale 1ns / 1ps

module xpak_container_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  xpak_in_if.sink    in_i,
  xpak_out_if.source out_o
);
  import xpak_pkg::*;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_final_q;

  // core handshake
  logic    out_room;
  logic    advance;
  result_t core_res;

  // the held byte moves on when the output register can take its result
  assign advance  = in_valid_q && out_room;
  // take a new byte when the input register is empty or emptying now
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.in_byte;
      in_final_q <= in_i.in_final;
    end
  end

  // parse state machine, steps once per held byte
  xpak_parse_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte_q),
    .final_i (in_final_q),
    .res_o   (core_res)
  );

  // output register, loaded only for bytes that give a result
  xpak_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (advance && core_res.valid),
    .res_i  (core_res),
    .room_o (out_room),
    .out_o  (out_o)
  );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// xpak container parser testbench
// streams whole containers, well-formed and damaged, through the parser with
// random gaps on both channels and checks every result against a predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import xpak_pkg::*;

  // parse phases of the predictor
  typedef enum bit [3:0] {
    PHASE_INTRO   = 4'd0,
    PHASE_IDXLEN  = 4'd1,
    PHASE_DATLEN  = 4'd2,
    PHASE_NAMELEN = 4'd3,
    PHASE_NAME    = 4'd4,
    PHASE_OFFSET  = 4'd5,
    PHASE_ELEN    = 4'd6,
    PHASE_DATA    = 4'd7,
    PHASE_OUTRO   = 4'd8,
    PHASE_DRAIN   = 4'd9
  } parse_phase_e;

  // ways of damaging a generated container
  typedef enum int {
    FLAW_NONE, FLAW_INTRO, FLAW_OUTRO, FLAW_INDEX_LEN, FLAW_ENTRY_LEN, FLAW_NAME_LEN,
    FLAW_TRAILING, FLAW_TRUNCATE, FLAW_NOISE, FLAW_SATURATE, FLAW_DATA_LEN
  } flaw_e;

  typedef struct {
    kind_e       kind;
    bit [7:0]    out_byte;
    bit [31:0]   entry_offset;
    bit [31:0]   entry_length;
    status_e     status;
  } parse_result_t;

  localparam int RANDOM_BYTES = 1450;
  localparam int STALL_AT     = 200;
  localparam int STALL_CYCLES = 400;

  // --------------------------------------------------------------------------
  // scoreboard: a private copy of the parser state and the expected results
  // --------------------------------------------------------------------------
  class container_scoreboard;
    parse_phase_e  phase;
    bit [2:0]      field_count;
    bit [31:0]     word_shift;
    bit [31:0]     index_left;
    bit [31:0]     data_total;
    bit [31:0]     data_left;
    bit [31:0]     name_left;
    bit [31:0]     held_offset;
    bit [32:0]     length_sum;
    status_e       first_error;
    parse_result_t expected_q[$];
    int            error_count;

    function new();
      error_count = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase       = PHASE_INTRO;
      field_count = 0;
      word_shift  = 0;
      index_left  = 0;
      data_total  = 0;
      data_left   = 0;
      name_left   = 0;
      held_offset = 0;
      length_sum  = 0;
      first_error = ST_OK;
    endfunction

    function void fail_with(status_e code);
      if (first_error == ST_OK) first_error = code;
      phase       = PHASE_DRAIN;
      field_count = 0;
    endfunction

    // big-endian word assembly, true on the fourth byte
    function bit take_word_byte(bit [7:0] b);
      bit done;
      word_shift = {word_shift[23:0], b};
      done = (field_count >= 3);
      field_count = done ? 3'd0 : field_count + 3'd1;
      return done;
    endfunction

    function void leave_index();
      field_count = 0;
      if (length_sum != {1'b0, data_total}) begin
        fail_with(ST_SUM_MISMATCH);
      end else if (data_total == 0) begin
        phase = PHASE_OUTRO;
      end else begin
        data_left = data_total;
        phase     = PHASE_DATA;
      end
    endfunction

    // note one accepted byte; returns 1 unless it was swallowed after an error
    function bit note_byte(bit [7:0] b, bit fin);
      parse_result_t r;
      bit            emit;
      bit            outro_done;
      bit            parsed;
      bit [2:0]      c;
      emit         = 0;
      outro_done   = 0;
      parsed       = (phase != PHASE_DRAIN);
      c            = field_count;
      r.kind         = KIND_NAME;
      r.out_byte     = 0;
      r.entry_offset = 0;
      r.entry_length = 0;
      r.status       = ST_OK;
      case (phase)
        PHASE_INTRO: begin
          if (b != INTRO_MAGIC[63 - 8 * int'(c) -: 8]) begin
            fail_with(ST_BAD_INTRO);
          end else if (c == 7) begin
            field_count = 0;
            word_shift  = 0;
            phase       = PHASE_IDXLEN;
          end else begin
            field_count = c + 3'd1;
          end
        end
        PHASE_IDXLEN: begin
          if (take_word_byte(b)) begin
            index_left = word_shift;
            phase      = PHASE_DATLEN;
          end
        end
        PHASE_DATLEN: begin
          if (take_word_byte(b)) begin
            data_total = word_shift;
            length_sum = 0;
            if (index_left == 0) leave_index();
            else phase = PHASE_NAMELEN;
          end
        end
        PHASE_NAMELEN, PHASE_NAME, PHASE_OFFSET, PHASE_ELEN: begin
          index_left = index_left - 1;
          if (phase == PHASE_NAMELEN) begin
            if (take_word_byte(b)) begin
              name_left = word_shift;
              phase     = (name_left == 0) ? PHASE_OFFSET : PHASE_NAME;
            end
          end else if (phase == PHASE_NAME) begin
            emit       = 1;
            r.kind     = KIND_NAME;
            r.out_byte = b;
            name_left  = name_left - 1;
            if (name_left == 0) begin
              field_count = 0;
              phase       = PHASE_OFFSET;
            end
          end else if (phase == PHASE_OFFSET) begin
            if (take_word_byte(b)) begin
              held_offset = word_shift;
              phase       = PHASE_ELEN;
            end
          end else begin
            if (take_word_byte(b)) begin
              emit           = 1;
              r.kind         = KIND_ENTRY;
              r.entry_offset = held_offset;
              r.entry_length = word_shift;
              // saturating sum of entry lengths
              length_sum = length_sum + {1'b0, word_shift};
              if (length_sum > SUM_CAP) length_sum = SUM_CAP;
              phase = PHASE_NAMELEN;
            end
          end
          if (index_left == 0) begin
            if (phase == PHASE_NAMELEN && field_count == 0) leave_index();
            else fail_with(ST_IDX_OVERRUN);
          end
        end
        PHASE_DATA: begin
          emit       = 1;
          r.kind     = KIND_DATA;
          r.out_byte = b;
          data_left  = data_left - 1;
          if (data_left == 0) begin
            field_count = 0;
            phase       = PHASE_OUTRO;
          end
        end
        PHASE_OUTRO: begin
          if (b != OUTRO_MAGIC[63 - 8 * int'(c) -: 8]) begin
            fail_with(ST_BAD_OUTRO);
          end else if (c == 7) begin
            if (fin) outro_done = 1;
            else fail_with(ST_TOTAL_LEN);
          end else begin
            field_count = c + 3'd1;
          end
        end
        default: phase = PHASE_DRAIN;
      endcase

      // the final byte only ever yields the status
      if (fin) begin
        r.kind         = KIND_STATUS;
        r.out_byte     = 0;
        r.entry_offset = 0;
        r.entry_length = 0;
        if (first_error != ST_OK) r.status = first_error;
        else if (outro_done) r.status = ST_OK;
        else r.status = ST_EARLY_END;
        expected_q.push_back(r);
        clear_state();
      end else if (emit) begin
        expected_q.push_back(r);
      end
      return parsed;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] ob, logic [31:0] off,
                               logic [31:0] len, logic [2:0] st);
      parse_result_t e;
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kind %0d byte %02h off %08h len %08h status %0d",
                   kind, ob, off, len, st);
        return;
      end
      e = expected_q.pop_front();
      if (kind !== e.kind || ob !== e.out_byte || off !== e.entry_offset ||
          len !== e.entry_length || st !== e.status) begin
        error_count++;
        if (error_count <= 10)
          $display("mismatch: expected kind %0d byte %02h off %08h len %08h status %0d, %s",
                   e.kind, e.out_byte, e.entry_offset, e.entry_length, e.status,
                   $sformatf("got kind %0d byte %02h off %08h len %08h status %0d",
                             kind, ob, off, len, st));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  xpak_in_if  in_bus ();
  xpak_out_if out_bus ();

  xpak_container_parser uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  container_scoreboard board = new();

  bit [7:0] frame_q[$];   // bytes of the container being sent
  int       parsed_count; // bytes that reached the parser, swallowed ones left out

  // --------------------------------------------------------------------------
  // stimulus tasks
  // --------------------------------------------------------------------------

  // one byte transfer on the input channel, after an idle gap
  task automatic send_byte(input bit [7:0] b, input bit fin, input int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.in_byte  <= b;
    in_bus.in_final <= fin;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    if (board.note_byte(b, fin)) parsed_count++;
  endtask

  task automatic push_word(input bit [31:0] w);
    for (int i = 3; i >= 0; i--) frame_q.push_back(w[8 * i +: 8]);
  endtask

  task automatic push_magic(input logic [63:0] magic);
    for (int i = 0; i < 8; i++) frame_q.push_back(magic[63 - 8 * i -: 8]);
  endtask

  // a container with small sections, then the requested damage, or bare noise bytes
  task automatic build_container(input flaw_e flaw);
    bit [31:0] lens[4];
    bit [31:0] idx_field;
    bit [31:0] data_field;
    bit [31:0] name_field;
    int        n_ent;
    int        data_size;
    int        remaining;
    int        name_size;
    int        pos;
    frame_q.delete();
    if (flaw == FLAW_NOISE) begin
      // sometimes start with a valid intro so noise lands in the header
      if ($urandom_range(0, 1)) push_magic(INTRO_MAGIC);
      repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end

    n_ent = $urandom_range(0, 3);
    if (flaw == FLAW_SATURATE) n_ent = $urandom_range(2, 3);
    if (flaw == FLAW_ENTRY_LEN || flaw == FLAW_NAME_LEN) n_ent = $urandom_range(1, 3);
    data_size = (n_ent == 0) ? 0 : $urandom_range(0, 12);
    remaining = data_size;
    for (int i = 0; i < n_ent; i++) begin
      lens[i]   = (i == n_ent - 1) ? remaining : $urandom_range(0, remaining);
      remaining = remaining - int'(lens[i]);
    end
    if (flaw == FLAW_SATURATE) begin
      lens[0] = 32'hFFFF_FFFF;
      lens[1] = 32'hFFFF_FFFF;
    end
    if (flaw == FLAW_ENTRY_LEN) lens[$urandom_range(0, n_ent - 1)] = $urandom;

    push_magic(INTRO_MAGIC);
    push_word(0);  // index length, patched below
    push_word(0);  // data length, patched below
    for (int e = 0; e < n_ent; e++) begin
      name_size  = $urandom_range(0, 5);
      name_field = (flaw == FLAW_NAME_LEN && e == 0) ? $urandom : name_size;
      push_word(name_field);
      repeat (name_size) frame_q.push_back(8'($urandom_range(0, 255)));
      push_word($urandom);
      push_word(lens[e]);
    end
    idx_field  = frame_q.size() - 16;
    data_field = data_size;
    if (flaw == FLAW_INDEX_LEN)
      idx_field = $urandom_range(0, 1) ? $urandom : idx_field + $urandom_range(0, 6) - 3;
    if (flaw == FLAW_DATA_LEN) data_field = $urandom;
    for (int i = 0; i < 4; i++) begin
      frame_q[8 + i]  = idx_field[31 - 8 * i -: 8];
      frame_q[12 + i] = data_field[31 - 8 * i -: 8];
    end
    repeat (data_size) frame_q.push_back(8'($urandom_range(0, 255)));
    push_magic(OUTRO_MAGIC);

    case (flaw)
      FLAW_INTRO: begin
        pos = $urandom_range(0, 7);
        frame_q[pos] ^= 8'($urandom_range(1, 255));
      end
      FLAW_OUTRO: begin
        pos = frame_q.size() - 1 - $urandom_range(0, 7);
        frame_q[pos] ^= 8'($urandom_range(1, 255));
      end
      FLAW_TRAILING: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
      FLAW_TRUNCATE: repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
      default: ;
    endcase
  endtask

  // send frame_q, final flag on its last byte; some containers go without gaps
  task automatic send_container();
    bit gappy;
    gappy = ($urandom_range(0, 3) != 0);
    foreach (frame_q[i])
      send_byte(frame_q[i], i == frame_q.size() - 1, gappy ? $urandom_range(0, 11) : 0);
  endtask

  // --------------------------------------------------------------------------
  // sender and end of run
  // --------------------------------------------------------------------------
  initial begin
    flaw_e flaw;
    in_bus.valid    = 1'b0;
    in_bus.in_byte  = 8'h00;
    in_bus.in_final = 1'b0;
    parsed_count    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: lone final bytes, an intro broken at its second byte,
    // and the smallest complete container with empty index and data
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'h00, 1'b1, 1);
    send_byte("X", 1'b1, 0);
    send_byte("X", 1'b0, 0);
    send_byte("Q", 1'b1, 2);
    frame_q.delete();
    push_magic(INTRO_MAGIC);
    push_word(0);
    push_word(0);
    push_magic(OUTRO_MAGIC);
    send_container();

    // random: mostly well-formed containers, the rest damaged or noise
    parsed_count = 0;
    while (parsed_count < RANDOM_BYTES) begin
      flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : flaw_e'($urandom_range(1, 10));
      build_container(flaw);
      send_container();
    end
    in_bus.valid <= 1'b0;

    // drain the expected results, then allow for any stray output
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    board.error_count += board.expected_q.size();
    if (board.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: random ready gaps, one long hold-off to fill the block
  // --------------------------------------------------------------------------
  initial begin
    int results_seen;
    bit rx_gappy;
    bit stalled;
    int gap;
    out_bus.ready = 1'b0;
    results_seen  = 0;
    rx_gappy      = 1'b1;
    stalled       = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!stalled && results_seen >= STALL_AT) begin
        // long hold-off while the sender keeps offering bytes
        stalled = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end
      if (results_seen % 64 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
      gap = rx_gappy ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
      board.check_result(out_bus.kind, out_bus.out_byte, out_bus.entry_offset,
                         out_bus.entry_length, out_bus.status);
      results_seen++;
    end
  end

  // hard limit on run length
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
